FILE: design/aab_pkg.sv
// ----------------------------------------------------------------------------
// aab_pkg: shared definitions for the ARGB alpha blend core
// Pixel layout constants and the per-channel blend arithmetic.
// ----------------------------------------------------------------------------
package aab_pkg;

    localparam int PIXEL_W = 32;
    localparam int CHAN_W  = 8;

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE  = 8'hFF;
    localparam logic [CHAN_W-1:0] GALPHA_RESET  = 8'hFF;

    typedef logic [PIXEL_W-1:0] pixel_t;
    typedef logic [CHAN_W-1:0]  chan_t;

    // One colour channel: d + floor((a * (s - d) * 257 + 32768) / 65536),
    // kept to eight bits. Taking the top bits of the signed sum gives the
    // floor directly.
    function automatic chan_t blend_channel(chan_t a, chan_t s, chan_t d);
        logic signed [9:0]  diff;
        logic signed [17:0] prod;
        logic signed [26:0] prod_ext;
        logic signed [26:0] vsum;
        logic signed [10:0] step;
        diff     = $signed({2'b00, s}) - $signed({2'b00, d});
        prod     = $signed({10'b0, a}) * $signed({{8{diff[9]}}, diff});
        prod_ext = {{9{prod[17]}}, prod};
        vsum     = (prod_ext <<< 8) + prod_ext + 27'sd32768;
        step     = vsum[26:16];
        return d + chan_t'(step[7:0]);
    endfunction

endpackage

FILE: design/argb_alpha_blend_core.sv
// ----------------------------------------------------------------------------
// argb_alpha_blend_core: ARGB8888 source-over blend with global opacity
// Blends one source pixel over one destination pixel per clock.
// ----------------------------------------------------------------------------
// A word (a source and destination pixel pair) is taken at every rising edge
// where start is high; busy is never raised, so the core takes one word per
// clock indefinitely. The blended pixel appears on out_pixel with done high
// for exactly one cycle, once the word has passed from the input stage into
// the result stage. The receiver cannot hold results off and must capture
// every done cycle. The core has two register stages: the input stage,
// which also forms the effective alpha, and the result stage after the
// per-channel multiply.
// The effective alpha is the source alpha minus (255 - global_alpha),
// saturated at zero. When it is zero the destination pixel passes through
// unchanged; otherwise each colour channel is blended with rounding and the
// output alpha byte is 0xFF. global_alpha resets to 255 and should only be
// written while no word is in flight.
module argb_alpha_blend_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  aab_pkg::pixel_t      src_pixel,
    input  aab_pkg::pixel_t      dst_pixel,
    input  logic                 global_alpha_we,
    input  aab_pkg::chan_t       global_alpha_wdata,
    output logic                 done,
    output aab_pkg::pixel_t      out_pixel
);
    import aab_pkg::*;

    chan_t  global_alpha_reg;
    logic   valid_reg;
    chan_t  alpha_reg;
    chan_t  alpha_next;
    pixel_t src_reg;
    pixel_t dst_reg;
    logic   done_reg;
    pixel_t out_pixel_reg;
    pixel_t out_pixel_next;
    chan_t  offset;
    chan_t  src_alpha;

    // The core never stalls the sender.
    assign busy = 1'b0;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            global_alpha_reg <= GALPHA_RESET;
        end
        else if (global_alpha_we)
        begin
            global_alpha_reg <= global_alpha_wdata;
        end
    end

    // The effective alpha is only two subtracts and a compare, so it is formed
    // ahead of the input register and the second stage only has to multiply.
    always_comb
    begin
        offset    = ALPHA_OPAQUE - global_alpha_reg;
        src_alpha = src_pixel[31:24];
        if (src_alpha > offset)
        begin
            alpha_next = src_alpha - offset;
        end
        else
        begin
            alpha_next = '0;
        end
    end

    // Input stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            alpha_reg <= alpha_next;
            src_reg   <= src_pixel;
            dst_reg   <= dst_pixel;
        end
    end

    // Blend stage: three channel multipliers working in parallel.
    always_comb
    begin
        if (alpha_reg == '0)
        begin
            out_pixel_next = dst_reg;
        end
        else
        begin
            out_pixel_next = {ALPHA_OPAQUE,
                              blend_channel(alpha_reg, src_reg[23:16], dst_reg[23:16]),
                              blend_channel(alpha_reg, src_reg[15:8],  dst_reg[15:8]),
                              blend_channel(alpha_reg, src_reg[7:0],   dst_reg[7:0])};
        end
    end

    // Result stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_reg)
        begin
            out_pixel_reg <= out_pixel_next;
        end
    end

    assign done      = done_reg;
    assign out_pixel = out_pixel_reg;

    // Every word in the input stage yields exactly one result strobe.
    a_valid_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |=> done_reg)
        else $error("word in input stage produced no result");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg |=> !done_reg)
        else $error("result strobe without a word");

    // Zero effective alpha passes the destination through untouched.
    a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && alpha_reg == '0) |=> (out_pixel_reg == $past(dst_reg)))
        else $error("destination not passed through at zero alpha");

    // A real blend always produces an opaque pixel.
    a_blend_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && alpha_reg != '0) |=> (out_pixel_reg[31:24] == ALPHA_OPAQUE))
        else $error("blended pixel not opaque");

endmodule
